// File: rtl/assert_macros.svh
// Assertion macros shared by the sorted linked queue RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property on every rising clock edge outside reset
`define SLQ_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// check that an antecedent implies a consequent in the same cycle
`define SLQ_ASSERT_IMPL(name, clk, rst, ante, cons, msg) \
   `SLQ_ASSERT(name, clk, rst, (ante) |-> (cons), msg)

`endif

// File: rtl/slq_pkg.sv
// Types, codes and sizes of the sorted linked queue.
// No dependencies; used by the interfaces and every module.
package slq_pkg;

   localparam int CAPACITY = 16;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int LINK_W   = IDX_W + 1;
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   localparam int OP_W     = 2;
   localparam int PID_W    = 16;
   localparam int TIME_W   = 32;
   localparam int PRIO_W   = 8;
   localparam int STATUS_W = 2;
   localparam int OCC_W    = 5;

   localparam logic [LINK_W-1:0] LINK_NULL = LINK_W'(CAPACITY);

   localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
   localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

   localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

   typedef struct packed {
      logic [PID_W-1:0]  pid;
      logic [TIME_W-1:0] tstamp;
      logic [PRIO_W-1:0] prio;
   } rec_type;

   typedef struct packed {
      logic [IDX_W-1:0]  rd_addr;
      logic              cell_we;
      logic [IDX_W-1:0]  cell_addr;
      rec_type           cell_data;
      logic              link_we;
      logic [IDX_W-1:0]  link_addr;
      logic [LINK_W-1:0] link_data;
   } store_cmd_type;

   typedef struct packed {
      rec_type           rec;
      logic [LINK_W-1:0] next;
   } store_rd_type;

   function automatic logic link_ok(input logic [LINK_W-1:0] lnk);
      return lnk < LINK_NULL;
   endfunction

endpackage

// File: rtl/slq_if.sv
// Request and response channel interfaces of the sorted linked queue.
// Depends on slq_pkg for field widths.
interface slq_req_if;
   logic                         valid;
   logic                         ready;
   logic [slq_pkg::OP_W-1:0]     op;
   logic [slq_pkg::PID_W-1:0]    key_pid;
   logic [slq_pkg::TIME_W-1:0]   rec_time;
   logic [slq_pkg::PRIO_W-1:0]   rec_prio;

   modport source (output valid, op, key_pid, rec_time, rec_prio, input ready);
   modport sink   (input valid, op, key_pid, rec_time, rec_prio, output ready);
endinterface

interface slq_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [slq_pkg::STATUS_W-1:0] status;
   logic [slq_pkg::OCC_W-1:0]    occupied;
   logic                         head_valid;
   logic [slq_pkg::PID_W-1:0]    head_pid;
   logic [slq_pkg::TIME_W-1:0]   head_time;
   logic [slq_pkg::PRIO_W-1:0]   head_prio;

   modport source (output valid, status, occupied, head_valid, head_pid, head_time,
                   head_prio, input ready);
   modport sink   (input valid, status, occupied, head_valid, head_pid, head_time,
                   head_prio, output ready);
endinterface

// File: rtl/slq_store.sv
// Cell pool of the sorted linked queue: record memory and forward link memory.
// Depends on slq_pkg; one registered read port, one write port per memory.
module slq_store (
   input  logic                   clock,
   input  logic                   reset,
   input  slq_pkg::store_cmd_type cmd,
   output slq_pkg::store_rd_type  rd
);
   import slq_pkg::*;

   rec_type           cell_mem [CAPACITY];
   logic [LINK_W-1:0] link_mem [CAPACITY];
   logic [CAPACITY-1:0] link_vld_ff;

   always_ff @(posedge clock) begin
      if (cmd.cell_we) begin
         cell_mem[cmd.cell_addr] <= cmd.cell_data;
      end
      if (cmd.link_we) begin
         link_mem[cmd.link_addr] <= cmd.link_data;
      end
      rd.rec <= cell_mem[cmd.rd_addr];
      if (link_vld_ff[cmd.rd_addr]) begin
         rd.next <= link_mem[cmd.rd_addr];
      end else begin
         rd.next <= LINK_W'(cmd.rd_addr) + LINK_W'(1);
      end
   end

   // unwritten forward links read as their reset chain i + 1
   always_ff @(posedge clock) begin
      if (reset) begin
         link_vld_ff <= '0;
      end else if (cmd.link_we) begin
         link_vld_ff[cmd.link_addr] <= 1'b1;
      end
   end

endmodule

// File: rtl/slq_seq.sv
// Sequencer of the sorted linked queue: list walk, link updates, response register.
// Depends on slq_pkg, slq_if and assert_macros.svh; drives slq_store.
`include "assert_macros.svh"

module slq_seq (
   input  logic                   clock,
   input  logic                   reset,
   slq_req_if.sink                req_chan,
   slq_rsp_if.source              rsp_chan,
   output slq_pkg::store_cmd_type cmd,
   input  slq_pkg::store_rd_type  rd
);
   import slq_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_POP    = 3'd1;
   localparam logic [2:0] S_WALK   = 3'd2;
   localparam logic [2:0] S_LINK2  = 3'd3;
   localparam logic [2:0] S_LINK1  = 3'd4;
   localparam logic [2:0] S_UNLINK = 3'd5;
   localparam logic [2:0] S_HEAD   = 3'd6;
   localparam logic [2:0] S_OUT    = 3'd7;

   logic [2:0]          state_ff, state_in;
   rec_type             rec_ff, rec_in;
   logic [IDX_W-1:0]    head_ff, head_in;
   logic [LINK_W-1:0]   free_ff, free_in;
   logic [LINK_W-1:0]   free_next_ff, free_next_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CNT_W-1:0]    steps_ff, steps_in;
   logic [LINK_W-1:0]   cur_ff, cur_in;
   logic [LINK_W-1:0]   before_ff, before_in;
   logic [STATUS_W-1:0] status_ff, status_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [OCC_W-1:0]    rsp_occ_ff, rsp_occ_in;
   logic                rsp_hv_ff, rsp_hv_in;
   rec_type             rsp_rec_ff, rsp_rec_in;

   logic                req_fire;
   logic                rsp_load;
   logic [LINK_W-1:0]   head_link;
   logic                head_ok;
   logic [CNT_W-1:0]    steps_next;

   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign rsp_load       = (state_ff == S_OUT) && (!rsp_valid_ff || rsp_chan.ready);
   assign head_link      = LINK_W'(head_ff);
   assign head_ok        = (count_ff != '0) && link_ok(head_link);
   assign steps_next     = steps_ff + CNT_W'(1);

   always_comb begin
      state_in      = state_ff;
      rec_in        = rec_ff;
      head_in       = head_ff;
      free_in       = free_ff;
      free_next_in  = free_next_ff;
      count_in      = count_ff;
      steps_in      = steps_ff;
      cur_in        = cur_ff;
      before_in     = before_ff;
      status_in     = status_ff;
      rsp_status_in = rsp_status_ff;
      rsp_occ_in    = rsp_occ_ff;
      rsp_hv_in     = rsp_hv_ff;
      rsp_rec_in    = rsp_rec_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;

      cmd           = '0;
      cmd.rd_addr   = head_ff;
      cmd.cell_addr = free_ff[IDX_W-1:0];
      cmd.cell_data = rec_ff;

      case (state_ff)
         S_IDLE: begin
            cmd.rd_addr = (req_chan.op == OP_INSERT) ? free_ff[IDX_W-1:0] : head_ff;
            if (req_fire) begin
               rec_in    = '{pid: req_chan.key_pid, tstamp: req_chan.rec_time,
                             prio: req_chan.rec_prio};
               status_in = ST_DONE;
               state_in  = S_HEAD;
               if (req_chan.op == OP_INSERT) begin
                  if (count_ff >= CNT_W'(CAPACITY) || !link_ok(free_ff)) begin
                     status_in = ST_FULL;
                  end else begin
                     state_in = S_POP;
                  end
               end else if (req_chan.op == OP_REMOVE) begin
                  if (!head_ok) begin
                     status_in = ST_EMPTY;
                  end else begin
                     state_in = S_UNLINK;
                  end
               end
            end
         end
         S_POP: begin
            free_next_in = rd.next;
            before_in    = LINK_NULL;
            steps_in     = '0;
            if (head_ok) begin
               cur_in   = head_link;
               state_in = S_WALK;
            end else begin
               cur_in   = LINK_NULL;
               state_in = S_LINK1;
            end
         end
         S_WALK: begin
            cmd.rd_addr = rd.next[IDX_W-1:0];
            if (rd.rec.pid >= rec_ff.pid) begin
               state_in = link_ok(before_ff) ? S_LINK2 : S_LINK1;
            end else begin
               before_in = cur_ff;
               if (steps_next < count_ff && link_ok(rd.next)) begin
                  cur_in   = rd.next;
                  steps_in = steps_next;
               end else begin
                  cur_in   = link_ok(rd.next) ? rd.next : LINK_NULL;
                  state_in = S_LINK2;
               end
            end
         end
         S_LINK2: begin
            cmd.link_we   = 1'b1;
            cmd.link_addr = before_ff[IDX_W-1:0];
            cmd.link_data = free_ff;
            state_in      = S_LINK1;
         end
         S_LINK1: begin
            cmd.cell_we   = 1'b1;
            cmd.link_we   = 1'b1;
            cmd.link_addr = free_ff[IDX_W-1:0];
            cmd.link_data = cur_ff;
            if (!link_ok(before_ff)) begin
               head_in = free_ff[IDX_W-1:0];
            end
            free_in  = free_next_ff;
            count_in = count_ff + CNT_W'(1);
            state_in = S_HEAD;
         end
         S_UNLINK: begin
            cmd.link_we   = 1'b1;
            cmd.link_addr = head_ff;
            cmd.link_data = free_ff;
            free_in       = head_link;
            count_in      = count_ff - CNT_W'(1);
            if (count_ff == CNT_W'(1) || !link_ok(rd.next)) begin
               head_in = '0;
            end else begin
               head_in = rd.next[IDX_W-1:0];
            end
            state_in = S_HEAD;
         end
         S_HEAD: begin
            state_in = S_OUT;
         end
         S_OUT: begin
            if (rsp_load) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_occ_in    = OCC_W'(count_ff);
               rsp_hv_in     = head_ok;
               rsp_rec_in    = head_ok ? rd.rec : '0;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         free_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         free_ff      <= free_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rec_ff        <= rec_in;
      free_next_ff  <= free_next_in;
      steps_ff      <= steps_in;
      cur_ff        <= cur_in;
      before_ff     <= before_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_occ_ff    <= rsp_occ_in;
      rsp_hv_ff     <= rsp_hv_in;
      rsp_rec_ff    <= rsp_rec_in;
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.status     = rsp_status_ff;
   assign rsp_chan.occupied   = rsp_occ_ff;
   assign rsp_chan.head_valid = rsp_hv_ff;
   assign rsp_chan.head_pid   = rsp_rec_ff.pid;
   assign rsp_chan.head_time  = rsp_rec_ff.tstamp;
   assign rsp_chan.head_prio  = rsp_rec_ff.prio;

   `SLQ_ASSERT(a_count_bound, clock, reset, count_ff <= CNT_W'(CAPACITY), "count overflow")
   `SLQ_ASSERT_IMPL(a_free_null_full, clock, reset, !link_ok(free_ff),
      count_ff == CNT_W'(CAPACITY), "free list empty while pool not full")
   `SLQ_ASSERT_IMPL(a_walk_bound, clock, reset, state_ff == S_WALK,
      steps_ff < count_ff, "walk past the record count")
   `SLQ_ASSERT(a_busy_after_req, clock, reset, req_fire |=> state_ff != S_IDLE,
      "request transfer left sequencer idle")

endmodule

// File: rtl/sorted_linked_queue.sv
// Sorted linked queue top level: sequencer plus cell pool.
// Depends on slq_pkg, slq_if, slq_store and slq_seq.
//
//   channel    dir  handshake     payload
//   req_chan   in   valid/ready   op, key_pid, rec_time, rec_prio
//   rsp_chan   out  valid/ready   status, occupied, head_valid, head_pid/time/prio
//
// Query, remove and refused operations do not walk the list; an insert does, and
// the ordered walk reads one linked cell per cycle through the single memory port.
// Reset is synchronous; the pool needs no clearing pass, unwritten links read i + 1.
// A stalled response register holds its transfer; the next request is taken meanwhile.
module sorted_linked_queue (
   input  logic      clock,
   input  logic      reset,
   slq_req_if.sink   req_chan,
   slq_rsp_if.source rsp_chan
);
   import slq_pkg::*;

   store_cmd_type cmd;
   store_rd_type  rd;

   slq_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .cmd      (cmd),
      .rd       (rd)
   );

   slq_store u_store (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .rd    (rd)
   );

endmodule
